FILE: hdl/fwalnum_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fwalnum_pkg;

   localparam logic [7:0] LEAD_FW   = 8'hEF;
   localparam logic [7:0] PLANE_BC  = 8'hBC;
   localparam logic [7:0] PLANE_BD  = 8'hBD;
   localparam logic [7:0] UPPER_OFS = 8'h60;
   localparam logic [7:0] LOWER_OFS = 8'h20;
   localparam logic [7:0] LEAD2_LO  = 8'hC0;
   localparam logic [7:0] LEAD3_LO  = 8'hE0;
   localparam logic [7:0] LEAD4_LO  = 8'hF0;
   localparam logic [7:0] DIGIT_LO  = 8'h90;
   localparam logic [7:0] DIGIT_HI  = 8'h99;
   localparam logic [7:0] UPPER_LO  = 8'hA1;
   localparam logic [7:0] UPPER_HI  = 8'hBA;
   localparam logic [7:0] LOWER_LO  = 8'h81;
   localparam logic [7:0] LOWER_HI  = 8'h9A;

   localparam int MAX_BEATS = 3;
   localparam int FIFO_AW_DEFAULT = 4;

   // up to three output bytes produced by one input byte
   typedef struct packed {
      logic [1:0]                     cnt;
      logic [MAX_BEATS-1:0][7:0]      data;
      logic [MAX_BEATS-1:0]           last;
   } fwalnum_beats_type;

endpackage

`default_nettype wire

FILE: hdl/fullwidth_alnum_to_ascii_utf8_top.sv
// Fullwidth alphanumeric to ASCII converter for a UTF-8 byte stream.
// Slave channel req_*: one string byte per beat in req_tdata, req_tlast on
// the final byte of a string. Master channel rsp_*: converted bytes, rsp_tlast
// on the final byte of the converted string.
// Fullwidth digits, capitals and lowercase (three bytes each) come out as
// one ASCII byte; the bytes EF and EF BC/BD are held while a match is pending
// and released when it fails or at the end of the string.
// An accepted byte is registered, converted in the following cycle into zero
// to three result bytes and written into a byte queue of 2**FIFO_AW entries;
// a result byte is offered at rsp_* once the queue holds it.
// Throughput is one input byte per cycle: req_tready stays high while the
// queue has room for two more worst-case bursts of three bytes.
// When the receiver stalls, results collect in the queue and req_tready drops
// once it runs short of space; nothing is lost.
// Reset (synchronous, active high) empties the queue and clears the hold and
// skip state, so the next byte starts a new string.
`timescale 1ns / 1ps
`default_nettype none

module fullwidth_alnum_to_ascii_utf8_top
   import fwalnum_pkg::*;
#(
   parameter int FIFO_AW = FIFO_AW_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_byte
   output logic             rsp_tlast
);

   localparam int DEPTH = 1 << FIFO_AW;
   localparam logic [FIFO_AW:0] ROOM_LIMIT = (FIFO_AW+1)'(DEPTH - 2 * MAX_BEATS);

   fwalnum_beats_type  beats;
   logic [FIFO_AW:0]   count;
   logic               in_accept;

   // room for the beat in the conversion stage plus this one
   assign req_tready = (count <= ROOM_LIMIT);
   assign in_accept  = req_tvalid && req_tready;

   fwalnum_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .in_accept (in_accept),
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .beats     (beats)
   );

   fwalnum_fifo #(
      .FIFO_AW (FIFO_AW)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .beats     (beats),
      .count     (count),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

`default_nettype wire

FILE: hdl/fwalnum_conv.sv
`timescale 1ns / 1ps
`default_nettype none

module fwalnum_conv
   import fwalnum_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_accept,
   input  wire logic [7:0]        in_byte,
   input  wire logic              in_last,
   output fwalnum_beats_type      beats
);

   typedef enum logic [2:0] {
      HOLD_NONE  = 3'b001,
      HOLD_EF    = 3'b010,
      HOLD_PLANE = 3'b100
   } hold_state_type;

   logic           s1_valid_ff, s1_valid_in;
   logic [7:0]     s1_byte_ff;
   logic           s1_last_ff;
   logic [1:0]     skip_ff, skip_in;
   hold_state_type hold_ff, hold_in;
   logic           plane_ff, plane_in;

   logic [2:0]                 n;
   logic [MAX_BEATS-1:0][7:0]  data;
   logic [MAX_BEATS-1:0]       lasts;
   logic                       fresh;
   logic [7:0]                 b;
   logic                       hit_upper, hit_lower;

   assign s1_valid_in = in_accept;
   assign b = s1_byte_ff;

   assign hit_upper = !plane_ff && ((b >= DIGIT_LO && b <= DIGIT_HI) ||
                                    (b >= UPPER_LO && b <= UPPER_HI));
   assign hit_lower = plane_ff && b >= LOWER_LO && b <= LOWER_HI;

   always_comb begin
      n        = 3'd0;
      data     = '0;
      lasts    = '0;
      fresh    = 1'b0;
      skip_in  = skip_ff;
      hold_in  = hold_ff;
      plane_in = plane_ff;

      if (skip_ff != 2'd0) begin
         data[n[1:0]] = b;
         n = n + 3'd1;
         skip_in = skip_ff - 2'd1;
      end else begin
         case (hold_ff)
            HOLD_EF: begin
               if (b == PLANE_BC || b == PLANE_BD) begin
                  hold_in  = HOLD_PLANE;
                  plane_in = (b == PLANE_BD);
               end else begin
                  data[n[1:0]] = LEAD_FW;
                  n = n + 3'd1;
                  hold_in = HOLD_NONE;
                  fresh = 1'b1;
               end
            end
            HOLD_PLANE: begin
               hold_in = HOLD_NONE;
               if (hit_upper) begin
                  data[n[1:0]] = b - UPPER_OFS;
                  n = n + 3'd1;
               end else if (hit_lower) begin
                  data[n[1:0]] = b - LOWER_OFS;
                  n = n + 3'd1;
               end else begin
                  data[n[1:0]] = LEAD_FW;
                  n = n + 3'd1;
                  data[n[1:0]] = plane_ff ? PLANE_BD : PLANE_BC;
                  n = n + 3'd1;
                  fresh = 1'b1;
               end
            end
            default: begin
               hold_in = HOLD_NONE;
               fresh = 1'b1;
            end
         endcase
      end

      // byte examined with nothing held
      if (fresh) begin
         if (b == LEAD_FW) begin
            hold_in = HOLD_EF;
         end else begin
            data[n[1:0]] = b;
            n = n + 3'd1;
            if (b >= LEAD2_LO && b < LEAD3_LO) begin
               skip_in = 2'd1;
            end else if (b >= LEAD4_LO) begin
               skip_in = 2'd3;
            end
         end
      end

      // end of string: flush held bytes, mark final beat, clear state
      if (s1_last_ff) begin
         if (hold_in != HOLD_NONE) begin
            data[n[1:0]] = LEAD_FW;
            n = n + 3'd1;
         end
         if (hold_in == HOLD_PLANE) begin
            data[n[1:0]] = plane_in ? PLANE_BD : PLANE_BC;
            n = n + 3'd1;
         end
         if (n != 3'd0) begin
            lasts[2'(n - 3'd1)] = 1'b1;
         end
         skip_in  = 2'd0;
         hold_in  = HOLD_NONE;
         plane_in = 1'b0;
      end
   end

   assign beats.cnt  = s1_valid_ff ? n[1:0] : 2'd0;
   assign beats.data = data;
   assign beats.last = lasts;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         skip_ff     <= 2'd0;
         hold_ff     <= HOLD_NONE;
         plane_ff    <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (s1_valid_ff) begin
            skip_ff  <= skip_in;
            hold_ff  <= hold_in;
            plane_ff <= plane_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         s1_byte_ff <= in_byte;
         s1_last_ff <= in_last;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/fwalnum_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module fwalnum_fifo
   import fwalnum_pkg::*;
#(
   parameter int FIFO_AW = FIFO_AW_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire fwalnum_beats_type   beats,
   output logic [FIFO_AW:0]         count,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output logic [7:0]               out_byte,
   output logic                     out_last
);

   localparam int DEPTH = 1 << FIFO_AW;

   logic [8:0]         mem [DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]   count_ff, count_in;
   logic               pop;

   assign out_valid = (count_ff != '0);
   assign pop       = out_valid && out_ready;
   assign out_byte  = mem[rd_ptr_ff][7:0];
   assign out_last  = mem[rd_ptr_ff][8];
   assign count     = count_ff;

   assign wr_ptr_in = wr_ptr_ff + FIFO_AW'(beats.cnt);
   assign rd_ptr_in = rd_ptr_ff + FIFO_AW'(pop);
   assign count_in  = count_ff + (FIFO_AW+1)'(beats.cnt) - (FIFO_AW+1)'(pop);

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_BEATS; i++) begin
         if (i < int'(beats.cnt)) begin
            mem[wr_ptr_ff + FIFO_AW'(i)] <= {beats.last[i], beats.data[i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: tb/sv/tb_fullwidth_alnum_to_ascii_utf8_top.sv
`timescale 1ns / 1ps

module tb_fullwidth_alnum_to_ascii_utf8_top
   import fwalnum_pkg::*;
();

   localparam int NUM_DIR       = 25;
   localparam int RANDOM_BYTES  = 245;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 20;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } byte_beat_type;

   // directed row: typed rows carry their own expected bytes, first byte leftmost
   typedef struct packed {
      logic [7:0]      b;
      logic            l;
      logic            typed;
      logic [1:0]      n;
      logic [0:2][7:0] want;
   } dir_row_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tlast  = 1'b0;
   logic       rsp_tready = 1'b0;
   logic       req_tready;
   logic       rsp_tvalid;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;

   // predictor state
   logic [1:0] skip_left  = 2'd0;
   logic [1:0] held_depth = 2'd0;
   logic       held_bd    = 1'b0;

   byte_beat_type expected_bytes [$];
   byte_beat_type stim_q [$];
   int            fail_count   = 0;
   int            quiet_cycles = 0;
   logic          calm         = 1'b0;

   always #1 clock = ~clock;

   fullwidth_alnum_to_ascii_utf8_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] in_byte
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [7:0] out_byte
      .rsp_tlast  (rsp_tlast)
   );

   // byte seen with nothing held
   function automatic void take_fresh(input logic [7:0] b, inout int n,
                                      inout logic [0:2][7:0] o);
      if (b == LEAD_FW) begin
         held_depth = 2'd1;
      end else begin
         o[n] = b;
         n++;
         if (b >= LEAD2_LO && b < LEAD3_LO) begin
            skip_left = 2'd1;
         end else if (b >= LEAD4_LO) begin
            skip_left = 2'd3;
         end
      end
   endfunction

   function automatic void convert_byte(input logic [7:0] b, input logic l,
                                        output int n, output logic [0:2][7:0] o);
      logic hit_up;
      logic hit_lo;
      n = 0;
      o = '0;
      hit_up = !held_bd && ((b >= DIGIT_LO && b <= DIGIT_HI) ||
                            (b >= UPPER_LO && b <= UPPER_HI));
      hit_lo = held_bd && b >= LOWER_LO && b <= LOWER_HI;
      if (skip_left != 2'd0) begin
         o[n] = b;
         n++;
         skip_left = skip_left - 2'd1;
      end else if (held_depth == 2'd1) begin
         if (b == PLANE_BC || b == PLANE_BD) begin
            held_depth = 2'd2;
            held_bd = (b == PLANE_BD);
         end else begin
            o[n] = LEAD_FW;
            n++;
            held_depth = 2'd0;
            take_fresh(b, n, o);
         end
      end else if (held_depth == 2'd2) begin
         held_depth = 2'd0;
         if (hit_up) begin
            o[n] = b - UPPER_OFS;
            n++;
         end else if (hit_lo) begin
            o[n] = b - LOWER_OFS;
            n++;
         end else begin
            o[n] = LEAD_FW;
            o[n+1] = held_bd ? PLANE_BD : PLANE_BC;
            n += 2;
            take_fresh(b, n, o);
         end
      end else begin
         take_fresh(b, n, o);
      end
      // end of string flushes whatever is still held
      if (l) begin
         if (held_depth >= 2'd1) begin
            o[n] = LEAD_FW;
            n++;
         end
         if (held_depth >= 2'd2) begin
            o[n] = held_bd ? PLANE_BD : PLANE_BC;
            n++;
         end
         skip_left  = 2'd0;
         held_depth = 2'd0;
         held_bd    = 1'b0;
      end
   endfunction

   function automatic void add_stim_byte(input logic [7:0] b);
      // now and then a string is cut short in the middle of a sequence
      stim_q.push_back('{data: b, last: ($urandom_range(99) < 3)});
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
                            input logic [1:0] tn, input logic [0:2][7:0] twant);
      int              cn;
      logic [0:2][7:0] co;
      while (!calm && $urandom_range(99) < 19) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= l;
      do @(posedge clock); while (!req_tready);
      convert_byte(b, l, cn, co);
      if (typed) begin
         cn = int'(tn);
         co = twant;
      end
      for (int i = 0; i < cn; i++) begin
         expected_bytes.push_back('{data: co[i], last: l && (i == cn - 1)});
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_bytes.size() != 0);
   endtask

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 19);
   end

   always @(posedge clock) begin
      byte_beat_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            $error("unexpected beat: out_byte %02h out_last %0b", rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            got = expected_bytes.pop_front();
            if (rsp_tdata !== got.data) begin
               $error("out_byte: expected %02h, actual %02h", got.data, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== got.last) begin
               $error("out_last: expected %0b, actual %0b", got.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("fullwidth_alnum_to_ascii_utf8_top test failed");
            $finish;
         end
      end
   end

   initial begin
      dir_row_type rows [NUM_DIR];
      int          str_len;
      int          roll;
      logic [7:0]  plane;
      rows = '{
         '{8'h00, 1'b0, 1'b1, 2'd1, {8'h00, 8'h00, 8'h00}},
         '{8'hFF, 1'b0, 1'b1, 2'd1, {8'hFF, 8'h00, 8'h00}},
         // three bytes after a four-byte lead pass untouched
         '{8'hEF, 1'b0, 1'b1, 2'd1, {8'hEF, 8'h00, 8'h00}},
         '{8'hBC, 1'b0, 1'b1, 2'd1, {8'hBC, 8'h00, 8'h00}},
         '{8'h90, 1'b0, 1'b1, 2'd1, {8'h90, 8'h00, 8'h00}},
         '{8'hEF, 1'b0, 1'b1, 2'd0, 24'h0},
         '{8'hBC, 1'b0, 1'b1, 2'd0, 24'h0},
         '{8'h90, 1'b0, 1'b0, 2'd0, 24'h0},
         '{8'hEF, 1'b0, 1'b0, 2'd0, 24'h0},
         '{8'hBC, 1'b0, 1'b0, 2'd0, 24'h0},
         '{8'hBA, 1'b0, 1'b0, 2'd0, 24'h0},
         '{8'hEF, 1'b0, 1'b0, 2'd0, 24'h0},
         '{8'hBD, 1'b0, 1'b0, 2'd0, 24'h0},
         '{8'h81, 1'b0, 1'b0, 2'd0, 24'h0},
         '{8'hEF, 1'b0, 1'b0, 2'd0, 24'h0},
         '{8'hBD, 1'b0, 1'b0, 2'd0, 24'h0},
         '{8'h9A, 1'b0, 1'b0, 2'd0, 24'h0},
         // second EF releases the first and starts a new hold
         '{8'hEF, 1'b0, 1'b0, 2'd0, 24'h0},
         '{8'hEF, 1'b0, 1'b0, 2'd0, 24'h0},
         '{8'hBD, 1'b1, 1'b0, 2'd0, 24'h0},
         // held EF BC released before a two-byte lead
         '{8'hEF, 1'b0, 1'b0, 2'd0, 24'h0},
         '{8'hBC, 1'b0, 1'b0, 2'd0, 24'h0},
         '{8'hDF, 1'b0, 1'b0, 2'd0, 24'h0},
         '{8'h7F, 1'b1, 1'b0, 2'd0, 24'h0},
         '{8'hEF, 1'b1, 1'b0, 2'd0, 24'h0}
      };

      // random strings, mostly well-formed utf-8 with fullwidth runs
      while (stim_q.size() < RANDOM_BYTES) begin
         str_len = $urandom_range(12, 1);
         for (int t = 0; t < str_len; t++) begin
            roll = $urandom_range(99);
            if (roll < 25) begin
               add_stim_byte(8'($urandom_range(8'h7F, 8'h00)));
            end else if (roll < 55) begin
               add_stim_byte(LEAD_FW);
               if ($urandom_range(1)) begin
                  add_stim_byte(PLANE_BD);
                  add_stim_byte(8'($urandom_range(LOWER_HI, LOWER_LO)));
               end else begin
                  add_stim_byte(PLANE_BC);
                  add_stim_byte($urandom_range(1) ? 8'($urandom_range(DIGIT_HI, DIGIT_LO))
                                                  : 8'($urandom_range(UPPER_HI, UPPER_LO)));
               end
            end else if (roll < 65) begin
               add_stim_byte(LEAD_FW);
               if ($urandom_range(1)) begin
                  plane = $urandom_range(1) ? PLANE_BD : PLANE_BC;
                  add_stim_byte(plane);
               end
               add_stim_byte(8'($urandom_range(8'hFF, 8'h00)));
            end else if (roll < 73) begin
               add_stim_byte(8'($urandom_range(LEAD3_LO - 1, LEAD2_LO)));
               add_stim_byte(8'($urandom_range(8'hFF, 8'h00)));
            end else if (roll < 80) begin
               add_stim_byte(8'($urandom_range(8'hFF, LEAD4_LO)));
               repeat (3) add_stim_byte(8'($urandom_range(8'hFF, 8'h00)));
            end else if (roll < 85) begin
               add_stim_byte(8'($urandom_range(LEAD_FW - 1, LEAD3_LO)));
               repeat (2) add_stim_byte(8'($urandom_range(8'hBF, 8'h80)));
            end else begin
               add_stim_byte(8'($urandom_range(8'hFF, 8'h00)));
            end
         end
         stim_q[stim_q.size()-1].last = 1'b1;
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         send_byte(rows[i].b, rows[i].l, rows[i].typed, rows[i].n, rows[i].want);
      end
      drain_results();

      foreach (stim_q[i]) begin
         calm = (i >= 90 && i < 150);
         if (i == stim_q.size() / 2) begin
            drain_results();
         end
         send_byte(stim_q[i].data, stim_q[i].last, 1'b0, 2'd0, 24'h0);
      end
      calm = 1'b0;
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("fullwidth_alnum_to_ascii_utf8_top test passed");
      end else begin
         $display("fullwidth_alnum_to_ascii_utf8_top test failed");
      end
      $finish;
   end

endmodule
